>>> hw/rtl/cbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

	localparam int MAX_WIDTH     = 512;
	localparam int SAMPLE_STRIDE = 4;
	localparam int PH_W          = 2;
	localparam int COL_W         = 9;
	localparam int ROW_W         = 9;
	localparam int WID_W         = 10;
	localparam int SUM_W         = 26;
	localparam int CNT_W         = 17;
	localparam int DIST_W        = 16;
	localparam int PIX_W         = 16;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int DIST_NUM_W = 37;
	localparam int WRK_W      = DIST_NUM_W + 1;
	localparam int REM_W      = 20;
	localparam int ALU_W      = 22;
	localparam int ROOT_W     = 19;
	localparam int ITER_W     = 6;

	localparam logic [DIST_NUM_W-1:0] DIST_SQ_NUM = 37'd102400000000;
	localparam logic [SUM_W-1:0]      SUM_MAX     = '1;
	localparam logic [CNT_W-1:0]      CNT_MAX     = '1;

	typedef enum logic [2:0] {
		REG_RED_LOW,
		REG_RED_HIGH,
		REG_GREEN_LOW,
		REG_GREEN_HIGH,
		REG_BLUE_LOW,
		REG_BLUE_HIGH,
		REG_FRAME_WIDTH,
		REG_MIN_PIXELS
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]       red_low;
		logic [7:0]       red_high;
		logic [7:0]       green_low;
		logic [7:0]       green_high;
		logic [7:0]       blue_low;
		logic [7:0]       blue_high;
		logic [WID_W-1:0] frame_width;
		logic [CNT_W-1:0] min_pixels;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		red_low:     8'd90,
		red_high:    8'd255,
		green_low:   8'd20,
		green_high:  8'd180,
		blue_low:    8'd0,
		blue_high:   8'd90,
		frame_width: 10'd320,
		min_pixels:  17'd50
	};

	typedef struct packed {
		logic [SUM_W-1:0] sum_columns;
		logic [SUM_W-1:0] sum_rows;
		logic [CNT_W-1:0] hit_count;
	} stats_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DIV_D,
		ST_SQRT,
		ST_EMIT
	} solve_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/cbc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbc_pix_if;
	logic                      valid;
	logic                      ready;
	logic [cbc_pkg::PIX_W-1:0] pixel_word;
	logic                      frame_end;

	modport source (output valid, output pixel_word, output frame_end, input ready);
	modport sink (input valid, input pixel_word, input frame_end, output ready);
endinterface

interface cbc_res_if;
	logic                       valid;
	logic                       ready;
	logic                       ball_found;
	logic [cbc_pkg::COL_W-1:0]  center_x;
	logic [cbc_pkg::ROW_W-1:0]  center_y;
	logic [cbc_pkg::DIST_W-1:0] distance_est;
	logic [cbc_pkg::CNT_W-1:0]  match_count;

	modport source (output valid, output ball_found, output center_x, output center_y,
		output distance_est, output match_count, input ready);
	modport sink (input valid, input ball_found, input center_x, input center_y,
		input distance_est, input match_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/color_blob_centroid.sv
// Pixels are taken at one per clock while no frame result is being computed.
// The pixel that ends a frame stops input until its result is loaded: a check state, then, if a
// blob is found, divisions for x, y and distance and a square root, all on one shared
// compare-subtract unit, and last an output load state that waits for the output register.
// The result then waits in its output register while the next frame streams in.
// Asynchronous reset restores the default thresholds and clears counters, sums and held values.
`timescale 1ns / 1ps
`default_nettype none

module color_blob_centroid (
	input  logic                       clk,
	input  logic                       arst_n,
	cbc_pix_if.sink                    pix,
	cbc_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cbc_pkg::ADDR_W-1:0] paddr,
	input  logic [cbc_pkg::DATA_W-1:0] pwdata,
	output logic [cbc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	cbc_pkg::cfg_t   cfg;
	cbc_pkg::stats_t stats;
	logic            solver_idle;
	logic            pix_accept;
	logic            frame_clear;

	assign pix.ready  = solver_idle;
	assign pix_accept = pix.valid & solver_idle;

	cbc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (pix_accept),
		.pixel_word (pix.pixel_word),
		.clear      (frame_clear),
		.cfg        (cfg),
		.stats      (stats)
	);

	cbc_solver u_solver (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (pix_accept & pix.frame_end),
		.stats      (stats),
		.min_pixels (cfg.min_pixels),
		.idle       (solver_idle),
		.clear      (frame_clear),
		.res        (res)
	);

endmodule

`default_nettype wire

>>> hw/rtl/cbc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module cbc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cbc_pkg::ADDR_W-1:0] paddr,
	input  logic [cbc_pkg::DATA_W-1:0] pwdata,
	output logic [cbc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output cbc_pkg::cfg_t              cfg
);

	cbc_pkg::cfg_t     cfg_q;
	cbc_pkg::cfg_reg_t reg_idx;
	logic              wr_en;

	assign reg_idx = cbc_pkg::cfg_reg_t'(paddr[cbc_pkg::ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cbc_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				cbc_pkg::REG_RED_LOW:     cfg_q.red_low     <= pwdata[7:0];
				cbc_pkg::REG_RED_HIGH:    cfg_q.red_high    <= pwdata[7:0];
				cbc_pkg::REG_GREEN_LOW:   cfg_q.green_low   <= pwdata[7:0];
				cbc_pkg::REG_GREEN_HIGH:  cfg_q.green_high  <= pwdata[7:0];
				cbc_pkg::REG_BLUE_LOW:    cfg_q.blue_low    <= pwdata[7:0];
				cbc_pkg::REG_BLUE_HIGH:   cfg_q.blue_high   <= pwdata[7:0];
				cbc_pkg::REG_FRAME_WIDTH: cfg_q.frame_width <= pwdata[cbc_pkg::WID_W-1:0];
				cbc_pkg::REG_MIN_PIXELS:  cfg_q.min_pixels  <= pwdata[cbc_pkg::CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			cbc_pkg::REG_RED_LOW:     prdata[7:0] = cfg_q.red_low;
			cbc_pkg::REG_RED_HIGH:    prdata[7:0] = cfg_q.red_high;
			cbc_pkg::REG_GREEN_LOW:   prdata[7:0] = cfg_q.green_low;
			cbc_pkg::REG_GREEN_HIGH:  prdata[7:0] = cfg_q.green_high;
			cbc_pkg::REG_BLUE_LOW:    prdata[7:0] = cfg_q.blue_low;
			cbc_pkg::REG_BLUE_HIGH:   prdata[7:0] = cfg_q.blue_high;
			cbc_pkg::REG_FRAME_WIDTH: prdata[cbc_pkg::WID_W-1:0] = cfg_q.frame_width;
			cbc_pkg::REG_MIN_PIXELS:  prdata[cbc_pkg::CNT_W-1:0] = cfg_q.min_pixels;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/cbc_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module cbc_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [cbc_pkg::PIX_W-1:0] pixel_word,
	input  logic                      clear,
	input  cbc_pkg::cfg_t             cfg,
	output cbc_pkg::stats_t           stats
);

	logic [cbc_pkg::PH_W-1:0]  phase_q;
	logic [cbc_pkg::COL_W-1:0] column_q;
	logic [cbc_pkg::ROW_W-1:0] row_q;
	cbc_pkg::stats_t           stats_q;

	logic [7:0]                red;
	logic [7:0]                green;
	logic [7:0]                blue;
	logic                      hit;
	logic                      wrap_col;
	logic [cbc_pkg::WID_W-1:0] width_eff;
	logic [cbc_pkg::SUM_W:0]   sum_c_ext;
	logic [cbc_pkg::SUM_W:0]   sum_r_ext;

	assign stats = stats_q;

	always_comb begin
		red   = {pixel_word[15:11], 3'b000};
		green = {pixel_word[10:8], pixel_word[7:5], 2'b00};
		blue  = {pixel_word[4:0], 3'b000};
		hit = (phase_q == '0)
			&& (red >= cfg.red_low) && (red <= cfg.red_high)
			&& (green >= cfg.green_low) && (green <= cfg.green_high)
			&& (blue >= cfg.blue_low) && (blue <= cfg.blue_high);

		if (cfg.frame_width == '0) begin
			width_eff = cbc_pkg::WID_W'(1);
		end else if (cfg.frame_width > cbc_pkg::WID_W'(cbc_pkg::MAX_WIDTH)) begin
			width_eff = cbc_pkg::WID_W'(cbc_pkg::MAX_WIDTH);
		end else begin
			width_eff = cfg.frame_width;
		end
		wrap_col = ({1'b0, column_q} + cbc_pkg::WID_W'(1)) >= width_eff;

		sum_c_ext = {1'b0, stats_q.sum_columns}
			+ {{(cbc_pkg::SUM_W + 1 - cbc_pkg::COL_W){1'b0}}, column_q};
		sum_r_ext = {1'b0, stats_q.sum_rows}
			+ {{(cbc_pkg::SUM_W + 1 - cbc_pkg::ROW_W){1'b0}}, row_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			column_q <= '0;
			row_q    <= '0;
			stats_q  <= '0;
		end else if (clear) begin
			phase_q  <= '0;
			column_q <= '0;
			row_q    <= '0;
			stats_q  <= '0;
		end else if (accept) begin
			if (phase_q == cbc_pkg::PH_W'(cbc_pkg::SAMPLE_STRIDE - 1)) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + cbc_pkg::PH_W'(1);
			end
			if (wrap_col) begin
				column_q <= '0;
				row_q    <= row_q + cbc_pkg::ROW_W'(1);
			end else begin
				column_q <= column_q + cbc_pkg::COL_W'(1);
			end
			if (hit) begin
				stats_q.sum_columns <= sum_c_ext[cbc_pkg::SUM_W] ? cbc_pkg::SUM_MAX
					: sum_c_ext[cbc_pkg::SUM_W-1:0];
				stats_q.sum_rows <= sum_r_ext[cbc_pkg::SUM_W] ? cbc_pkg::SUM_MAX
					: sum_r_ext[cbc_pkg::SUM_W-1:0];
				if (stats_q.hit_count != cbc_pkg::CNT_MAX) begin
					stats_q.hit_count <= stats_q.hit_count + cbc_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/cbc_cmpsub.sv
`timescale 1ns / 1ps
`default_nettype none

module cbc_cmpsub (
	input  logic [cbc_pkg::ALU_W-1:0] a,
	input  logic [cbc_pkg::ALU_W-1:0] b,
	output logic                      ge,
	output logic [cbc_pkg::ALU_W-1:0] diff
);

	logic borrow;

	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

`default_nettype wire

>>> hw/rtl/cbc_solver.sv
`timescale 1ns / 1ps
`default_nettype none

module cbc_solver (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  cbc_pkg::stats_t           stats,
	input  logic [cbc_pkg::CNT_W-1:0] min_pixels,
	output logic                      idle,
	output logic                      clear,
	cbc_res_if.source                 res
);

	cbc_pkg::solve_state_t      state_q;
	cbc_pkg::solve_state_t      state_d;
	logic [cbc_pkg::ITER_W-1:0] iter_q;
	logic [cbc_pkg::ITER_W-1:0] iter_d;
	logic [cbc_pkg::WRK_W-1:0]  wrk_q;
	logic [cbc_pkg::WRK_W-1:0]  wrk_d;
	logic [cbc_pkg::REM_W-1:0]  rem_q;
	logic [cbc_pkg::REM_W-1:0]  rem_d;
	logic [cbc_pkg::ROOT_W-1:0] root_q;
	logic [cbc_pkg::ROOT_W-1:0] root_d;
	logic                       found_q;
	logic                       found_d;
	logic [cbc_pkg::COL_W-1:0]  held_x_q;
	logic [cbc_pkg::COL_W-1:0]  held_x_d;
	logic [cbc_pkg::ROW_W-1:0]  held_y_q;
	logic [cbc_pkg::ROW_W-1:0]  held_y_d;
	logic [cbc_pkg::DIST_W-1:0] held_dist_q;
	logic [cbc_pkg::DIST_W-1:0] held_dist_d;

	logic                       res_valid_q;
	logic                       out_found_q;
	logic [cbc_pkg::COL_W-1:0]  out_x_q;
	logic [cbc_pkg::ROW_W-1:0]  out_y_q;
	logic [cbc_pkg::DIST_W-1:0] out_dist_q;
	logic [cbc_pkg::CNT_W-1:0]  out_count_q;
	logic                       out_load;

	logic [cbc_pkg::ALU_W-1:0]  alu_a;
	logic [cbc_pkg::ALU_W-1:0]  alu_b;
	logic                       alu_ge;
	logic [cbc_pkg::ALU_W-1:0]  alu_diff;
	logic [cbc_pkg::WRK_W-1:0]  wrk_div;
	logic [cbc_pkg::REM_W-1:0]  rem_step;
	logic [cbc_pkg::ITER_W-1:0] iter_dec;

	cbc_cmpsub u_cmpsub (
		.a    (alu_a),
		.b    (alu_b),
		.ge   (alu_ge),
		.diff (alu_diff)
	);

	assign idle             = (state_q == cbc_pkg::ST_IDLE);
	assign res.valid        = res_valid_q;
	assign res.ball_found   = out_found_q;
	assign res.center_x     = out_x_q;
	assign res.center_y     = out_y_q;
	assign res.distance_est = out_dist_q;
	assign res.match_count  = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbc_pkg::ST_IDLE;
			iter_q      <= '0;
			found_q     <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			held_dist_q <= '0;
		end else begin
			state_q     <= state_d;
			iter_q      <= iter_d;
			found_q     <= found_d;
			held_x_q    <= held_x_d;
			held_y_q    <= held_y_d;
			held_dist_q <= held_dist_d;
		end
	end

	always_ff @(posedge clk) begin
		wrk_q  <= wrk_d;
		rem_q  <= rem_d;
		root_q <= root_d;
	end

	always_comb begin
		state_d     = state_q;
		iter_d      = iter_q;
		wrk_d       = wrk_q;
		rem_d       = rem_q;
		root_d      = root_q;
		found_d     = found_q;
		held_x_d    = held_x_q;
		held_y_d    = held_y_q;
		held_dist_d = held_dist_q;
		out_load    = 1'b0;
		clear       = 1'b0;

		if (state_q == cbc_pkg::ST_SQRT) begin
			alu_a = {rem_q, wrk_q[cbc_pkg::WRK_W-1 -: 2]};
			alu_b = {1'b0, root_q, 2'b01};
		end else begin
			alu_a = {1'b0, rem_q, wrk_q[cbc_pkg::WRK_W-1]};
			alu_b = {{(cbc_pkg::ALU_W - cbc_pkg::CNT_W){1'b0}}, stats.hit_count};
		end
		wrk_div  = {wrk_q[cbc_pkg::WRK_W-2:0], alu_ge};
		rem_step = alu_ge ? alu_diff[cbc_pkg::REM_W-1:0] : alu_a[cbc_pkg::REM_W-1:0];
		iter_dec = iter_q - cbc_pkg::ITER_W'(1);

		unique case (state_q)
			cbc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = cbc_pkg::ST_START;
				end
			end
			cbc_pkg::ST_START: begin
				found_d = stats.hit_count > min_pixels;
				if (found_d) begin
					wrk_d   = {stats.sum_columns, {(cbc_pkg::WRK_W - cbc_pkg::SUM_W){1'b0}}};
					rem_d   = '0;
					iter_d  = cbc_pkg::ITER_W'(cbc_pkg::SUM_W - 1);
					state_d = cbc_pkg::ST_DIV_X;
				end else begin
					state_d = cbc_pkg::ST_EMIT;
				end
			end
			cbc_pkg::ST_DIV_X: begin
				wrk_d  = wrk_div;
				rem_d  = rem_step;
				iter_d = iter_dec;
				if (iter_q == '0) begin
					held_x_d = (|wrk_div[cbc_pkg::SUM_W-1:cbc_pkg::COL_W]) ? '1
						: wrk_div[cbc_pkg::COL_W-1:0];
					wrk_d   = {stats.sum_rows, {(cbc_pkg::WRK_W - cbc_pkg::SUM_W){1'b0}}};
					rem_d   = '0;
					iter_d  = cbc_pkg::ITER_W'(cbc_pkg::SUM_W - 1);
					state_d = cbc_pkg::ST_DIV_Y;
				end
			end
			cbc_pkg::ST_DIV_Y: begin
				wrk_d  = wrk_div;
				rem_d  = rem_step;
				iter_d = iter_dec;
				if (iter_q == '0) begin
					held_y_d = (|wrk_div[cbc_pkg::SUM_W-1:cbc_pkg::ROW_W]) ? '1
						: wrk_div[cbc_pkg::ROW_W-1:0];
					wrk_d   = {cbc_pkg::DIST_SQ_NUM, 1'b0};
					rem_d   = '0;
					iter_d  = cbc_pkg::ITER_W'(cbc_pkg::DIST_NUM_W - 1);
					state_d = cbc_pkg::ST_DIV_D;
				end
			end
			cbc_pkg::ST_DIV_D: begin
				wrk_d  = wrk_div;
				rem_d  = rem_step;
				iter_d = iter_dec;
				if (iter_q == '0) begin
					rem_d   = '0;
					root_d  = '0;
					iter_d  = cbc_pkg::ITER_W'(cbc_pkg::ROOT_W - 1);
					state_d = cbc_pkg::ST_SQRT;
				end
			end
			cbc_pkg::ST_SQRT: begin
				wrk_d  = {wrk_q[cbc_pkg::WRK_W-3:0], 2'b00};
				rem_d  = rem_step;
				root_d = {root_q[cbc_pkg::ROOT_W-2:0], alu_ge};
				iter_d = iter_dec;
				if (iter_q == '0) begin
					held_dist_d = (|root_d[cbc_pkg::ROOT_W-1:cbc_pkg::DIST_W]) ? '1
						: root_d[cbc_pkg::DIST_W-1:0];
					state_d = cbc_pkg::ST_EMIT;
				end
			end
			cbc_pkg::ST_EMIT: begin
				if (!res_valid_q || res.ready) begin
					out_load = 1'b1;
					clear    = 1'b1;
					state_d  = cbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cbc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_q;
			out_x_q     <= held_x_q;
			out_y_q     <= held_y_q;
			out_dist_q  <= held_dist_q;
			out_count_q <= stats.hit_count;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbc_pkg::ST_DIV_X || state_q == cbc_pkg::ST_DIV_Y
			|| state_q == cbc_pkg::ST_DIV_D)
		|-> (rem_q < cbc_pkg::REM_W'(stats.hit_count)))
		else $error("division remainder not below the pixel count");

	a_stats_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cbc_pkg::ST_IDLE && state_q != cbc_pkg::ST_START) |-> $stable(stats))
		else $error("frame sums changed while the result was being computed");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbc_pkg::ST_IDLE && start) |=> (state_q == cbc_pkg::ST_START))
		else $error("frame end request did not start the solver");

	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbc_pkg::ST_EMIT && (!res.valid || res.ready))
		|=> (res.valid && state_q == cbc_pkg::ST_IDLE))
		else $error("result was not loaded into the output register");

endmodule

`default_nettype wire
